FILE: rtl/mlpsd_pkg.sv
// Shared types and constants of the masked length-prefixed string decoder.
`timescale 1ns / 1ps
`default_nettype none

package mlpsd_pkg;

  localparam logic [15:0] WideMaskInit   = 16'hAAAA;
  localparam logic [15:0] NarrowMaskInit = 16'h00AA;
  localparam logic [7:0]  HdrEmpty       = 8'd0;
  localparam logic [7:0]  HdrWideExt     = 8'd127;
  localparam logic [7:0]  HdrNarrowExt   = 8'd128;

  localparam int unsigned CodeW   = 16;
  localparam int unsigned RemainW = 31;
  localparam int unsigned LenW    = 32;

  typedef struct packed {
    logic [CodeW-1:0] char_code;
    logic             last;
    logic             empty_res;
    logic             wide;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/masked_length_prefixed_string_decoder_core.sv
// Top level of the masked length-prefixed string decoder.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - Input channel (in_valid_i / in_ready_o / in_byte_i) takes one raw byte of
//   the stream per item. Header, length and character bytes share it.
// - Output channel (out_valid_o / out_ready_i) carries one decoded character
//   per item: char_code_o, last_o on the final character of a string,
//   empty_res_o for an empty string (with last_o set and char_code_o zero),
//   and wide_o for a 16-bit character string.
// - Throughput: one input byte per cycle while the skid register is empty,
//   set by the single decode step between the byte port and the result
//   register. Header bytes, length bytes and the low byte of a wide character
//   leave no output item, except a header or last length byte that gives an
//   empty string. The result of a completing byte is registered in the
//   result register, or in the skid register while the output stalls.
// - Stall: when the receiver holds out_ready_i low, the result register holds
//   its item and one further result goes into a skid register; in_ready_o
//   drops only while the skid register is full.
// - Reset: rst_ni clears the decode state to the header phase, sets the mask
//   to its wide start value and empties both result registers.
module masked_length_prefixed_string_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      char_code_o,
  output logic             last_o,
  output logic             empty_res_o,
  output logic             wide_o
);

  localparam logic [1:0] PhHeader = 2'd0;
  localparam logic [1:0] PhLength = 2'd1;
  localparam logic [1:0] PhChars  = 2'd2;

  // Decode state
  logic [1:0]                       phase_q, phase_d;
  logic [mlpsd_pkg::RemainW-1:0]    remaining_q, remaining_d;
  logic [mlpsd_pkg::LenW-1:0]       len_shift_q, len_shift_d;
  logic [1:0]                       len_cnt_q, len_cnt_d;
  logic                             wide_mode_q, wide_mode_d;
  logic [15:0]                      mask_q, mask_d;
  logic [7:0]                       low_half_q, low_half_d;
  logic                             low_held_q, low_held_d;

  // Result registers: output stage and skid stage
  mlpsd_pkg::res_t out_q, skid_q, res;
  logic            out_valid_q, skid_valid_q;
  logic            res_valid;

  logic in_fire, out_fire;
  logic [mlpsd_pkg::LenW-1:0]    len_full;
  logic [mlpsd_pkg::RemainW-1:0] remain_dec;
  logic [15:0]                   code;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign remain_dec  = remaining_q - mlpsd_pkg::RemainW'(1);

  // Merge the current length byte into its lane
  always_comb begin
    len_full = len_shift_q;
    case (len_cnt_q)
      2'd0: len_full[7:0]   = len_shift_q[7:0]   | in_byte_i;
      2'd1: len_full[15:8]  = len_shift_q[15:8]  | in_byte_i;
      2'd2: len_full[23:16] = len_shift_q[23:16] | in_byte_i;
      default: len_full[31:24] = len_shift_q[31:24] | in_byte_i;
    endcase
  end

  // One decode step per accepted byte
  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    len_shift_d = len_shift_q;
    len_cnt_d   = len_cnt_q;
    wide_mode_d = wide_mode_q;
    mask_d      = mask_q;
    low_half_d  = low_half_q;
    low_held_d  = low_held_q;
    res_valid   = 1'b0;
    res         = '0;
    code        = '0;

    case (phase_q)
      PhLength: begin
        len_shift_d = len_full;
        if (len_cnt_q != 2'd3) begin
          len_cnt_d = len_cnt_q + 2'd1;
        end else begin
          len_cnt_d = 2'd0;
          if (len_full == '0 || len_full[mlpsd_pkg::LenW-1]) begin
            // Zero or negative length: empty string
            phase_d       = PhHeader;
            res_valid     = 1'b1;
            res.last      = 1'b1;
            res.empty_res = 1'b1;
            res.wide      = wide_mode_q;
          end else begin
            phase_d     = PhChars;
            remaining_d = len_full[mlpsd_pkg::RemainW-1:0];
            mask_d      = wide_mode_q ? mlpsd_pkg::WideMaskInit : mlpsd_pkg::NarrowMaskInit;
            low_half_d  = '0;
            low_held_d  = 1'b0;
          end
        end
      end

      PhChars: begin
        if (wide_mode_q && !low_held_q) begin
          // Hold the low byte of a wide character
          low_half_d = in_byte_i;
          low_held_d = 1'b1;
        end else begin
          if (wide_mode_q) begin
            code       = {in_byte_i, low_half_q} ^ mask_q;
            mask_d     = mask_q + 16'd1;
            low_held_d = 1'b0;
          end else begin
            code   = {8'h00, in_byte_i ^ mask_q[7:0]};
            mask_d = {8'h00, mask_q[7:0] + 8'd1};
          end
          remaining_d   = remain_dec;
          res_valid     = 1'b1;
          res.char_code = code;
          res.wide      = wide_mode_q;
          if (remain_dec == '0) begin
            phase_d  = PhHeader;
            res.last = 1'b1;
          end
        end
      end

      default: begin
        // Header phase; the unused code behaves the same
        if (in_byte_i == mlpsd_pkg::HdrEmpty) begin
          wide_mode_d   = 1'b0;
          phase_d       = PhHeader;
          res_valid     = 1'b1;
          res.last      = 1'b1;
          res.empty_res = 1'b1;
        end else if (in_byte_i == mlpsd_pkg::HdrWideExt ||
                     in_byte_i == mlpsd_pkg::HdrNarrowExt) begin
          wide_mode_d = (in_byte_i == mlpsd_pkg::HdrWideExt);
          len_shift_d = '0;
          len_cnt_d   = 2'd0;
          phase_d     = PhLength;
        end else begin
          wide_mode_d = !in_byte_i[7];
          phase_d     = PhChars;
          low_half_d  = '0;
          low_held_d  = 1'b0;
          if (!in_byte_i[7]) begin
            remaining_d = mlpsd_pkg::RemainW'(in_byte_i);
            mask_d      = mlpsd_pkg::WideMaskInit;
          end else begin
            // Narrow length is the magnitude of the signed header
            remaining_d = mlpsd_pkg::RemainW'(8'(~in_byte_i + 8'd1));
            mask_d      = mlpsd_pkg::NarrowMaskInit;
          end
        end
      end
    endcase
  end

  // Advance decode state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      remaining_q <= '0;
      len_shift_q <= '0;
      len_cnt_q   <= '0;
      wide_mode_q <= 1'b0;
      mask_q      <= mlpsd_pkg::WideMaskInit;
      low_half_q  <= '0;
      low_held_q  <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      len_shift_q <= len_shift_d;
      len_cnt_q   <= len_cnt_d;
      wide_mode_q <= wide_mode_d;
      mask_q      <= mask_d;
      low_half_q  <= low_half_d;
      low_held_q  <= low_held_d;
    end
  end

  // Result and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire && res_valid) begin
        if (out_valid_q && !out_ready_i) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payloads: load output from skid when draining, else from decode
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = out_q.char_code;
  assign last_o      = out_q.last;
  assign empty_res_o = out_q.empty_res;
  assign wide_o      = out_q.wide;

endmodule

`default_nettype wire

FILE: rtl/mlpsd_checker.sv
// Port-level checker of the string decoder and its bind.
`timescale 1ns / 1ps
`default_nettype none

module mlpsd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] char_code_o,
  input wire logic        last_o,
  input wire logic        empty_res_o,
  input wire logic        wide_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("stalled output item dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(char_code_o) && $stable(last_o) && $stable(empty_res_o) && $stable(wide_o))
    else $error("stalled output item changed");

  // An empty-string item closes its string and carries no character
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_o && char_code_o == 16'd0)
    else $error("empty item without last or with a character");

  // Narrow characters are zero-extended
  a_narrow_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !wide_o |-> char_code_o[15:8] == 8'd0)
    else $error("narrow character has upper bits set");

endmodule

bind masked_length_prefixed_string_decoder_core mlpsd_checker u_mlpsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .char_code_o (char_code_o),
  .last_o      (last_o),
  .empty_res_o (empty_res_o),
  .wide_o      (wide_o)
);

`default_nettype wire
